FILE: rtl/core/fncp_pkg.sv
// Shared types, constants and arithmetic helpers for the friction NCP residual pipeline.
package fncp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRICTION = 2'd0,
        REG_BLEND    = 2'd1,
        REG_TOL      = 2'd2
    } cfg_reg_t;

    localparam logic [30:0] FRICTION_RST = 31'd0;
    localparam logic [16:0] BLEND_RST    = 17'd62259;
    localparam logic [16:0] TOL_RST      = 17'd1;

    // Product magnitudes saturate here
    localparam logic [63:0] CAP_MAG = 64'h2000_0000_0000_0000;

    // Everything one item carries down the pipeline; each stage fills its part
    typedef struct packed {
        logic               contact;
        logic               lowp;
        logic               u_nonneg;
        logic               s_pos;
        logic               s_neg;
        logic signed [31:0] u;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic [63:0]        mup;
        logic               p_neg;
        logic [32:0]        umag;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0]        amag;
        logic [63:0]        bmag;
        logic               a_small;
        logic               b_small;
        logic [6:0]         k;
        logic [63:0]        t1_lo;
        logic [63:0]        t1_hi;
        logic [63:0]        t2_lo;
        logic [63:0]        t2_hi;
        logic signed [63:0] t1;
        logic signed [63:0] t2;
        logic [30:0]        sa;
        logic [30:0]        sb;
        logic [63:0]        y00;
        logic [63:0]        y01;
        logic [63:0]        y10;
        logic [63:0]        y11;
        logic signed [63:0] y;
        logic [63:0]        sq_a;
        logic [63:0]        sq_b;
        logic [63:0]        rem;
        logic [63:0]        res;
        logic [63:0]        r;
        logic signed [63:0] dif;
        logic               rzero;
        logic [6:0]         j;
        logic [63:0]        x_lo;
        logic [63:0]        x_hi;
        logic signed [63:0] x;
        logic [31:0]        rd;
        logic [32:0]        rem_a;
        logic [32:0]        rem_b;
        logic [31:0]        qa;
        logic [31:0]        qb;
        logic               full_a;
        logic               full_b;
        logic signed [63:0] ml_a;
        logic signed [63:0] ml_b;
        logic signed [63:0] g2;
        logic signed [63:0] gv;
        logic [63:0]        jp_lo;
        logic [63:0]        jp_hi;
        logic [63:0]        vx_lo;
        logic [63:0]        vx_hi;
        logic [63:0]        vy_lo;
        logic [63:0]        vy_hi;
        logic               dax_neg;
        logic               day_neg;
        logic [31:0]        residual;
        logic [31:0]        jac_self;
        logic [31:0]        jac_pressure;
        logic [31:0]        jac_vel_x;
        logic [31:0]        jac_vel_y;
    } pipe_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Scale a product magnitude down, saturate it and apply the sign
    function automatic logic signed [63:0] fin(input logic [127:0] prod, input logic neg,
                                               input int unsigned f);
        logic [127:0] sh;
        logic [63:0]  m;
        sh = prod >> f;
        if (prod[127:64] != 64'd0 || sh[63:0] > CAP_MAG) begin
            m = CAP_MAG;
        end else begin
            m = sh[63:0];
        end
        fin = neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // Position of the highest set bit plus one, zero for zero
    function automatic logic [6:0] bit_len(input logic [63:0] v);
        bit_len = 7'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                bit_len = 7'(i + 1);
            end
        end
    endfunction

endpackage

FILE: rtl/core/friction_ncp_residual_jacobian.sv
// Pipelined friction complementarity residual and Jacobian, one contact node per transfer.
//
// Takes one node per clock unless the pipeline holds, and returns one result per node.
// The pipeline holds a 32-stage square root and two FRAC_BITS-stage dividers
// that form the ratios against the radius. When the result is not taken the whole
// pipeline holds, and s_tready drops in the same cycle. Configuration registers are
// read live by the stages, not held per node, so write them only with the pipeline empty.
module friction_ncp_residual_jacobian #(
    parameter int FRAC_BITS = fncp_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: normal_x[17:0], normal_y[35:18], vel_x[67:36], vel_y[99:68],
    //        vel_z[131:100], pressure[163:132], multiplier[195:164], zero pad
    input  logic [199:0] s_tdata,
    // tuser: in_contact[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: residual[31:0], jac_self[63:32], jac_pressure[95:64],
    //        jac_vel_x[127:96], jac_vel_y[159:128]
    output logic [159:0] m_tdata
);
    import fncp_pkg::*;

    localparam int S_IN  = 0;
    localparam int S_AB  = 1;
    localparam int S_NRM = 2;
    localparam int S_SHF = 3;
    localparam int S_SQ  = 4;
    localparam int S_RAD = 5;
    localparam int NSQ   = 32;
    localparam int SQ0   = S_RAD + 1;
    localparam int S_R   = SQ0 + NSQ;
    localparam int S_DP  = S_R + 1;
    localparam int DV0   = S_DP + 1;
    localparam int S_G1  = DV0 + FRAC_BITS;
    localparam int S_G2  = S_G1 + 1;
    localparam int S_J1  = S_G2 + 1;
    localparam int S_J2  = S_J1 + 1;
    localparam int NST   = S_J2 + 1;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    logic [30:0] friction_coeff_reg;
    logic [16:0] blend_weight_reg;
    logic [16:0] tolerance_reg;

    pipe_t           d_reg  [NST];
    pipe_t           d_next [NST];
    logic [NST-1:0]  v_reg;
    logic [NST-1:0]  v_next;
    logic            ce;

    // Advance whenever the output slot is free or being drained
    assign ce       = m_tready | ~v_reg[NST-1];
    assign s_tready = ce;
    assign m_tvalid = v_reg[NST-1];
    assign m_tdata  = {d_reg[NST-1].jac_vel_y, d_reg[NST-1].jac_vel_x,
                       d_reg[NST-1].jac_pressure, d_reg[NST-1].jac_self,
                       d_reg[NST-1].residual};
    assign v_next   = {v_reg[NST-2:0], s_tvalid};

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            friction_coeff_reg <= FRICTION_RST;
            blend_weight_reg   <= BLEND_RST;
            tolerance_reg      <= TOL_RST;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRICTION: friction_coeff_reg <= cfg_data;
                REG_BLEND:    blend_weight_reg   <= cfg_data[16:0];
                REG_TOL:      tolerance_reg      <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= v_next;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NST; i++) begin
                d_reg[i] <= d_next[i];
            end
        end
    end

    always_comb begin
        pipe_t              c;
        pipe_t              n;
        logic signed [63:0] diff_v;
        logic signed [63:0] vdt_v;
        logic signed [63:0] bm_v;
        logic signed [63:0] oml_v;
        logic signed [63:0] lam_v;
        logic signed [63:0] eps_v;
        logic [63:0]        mag_v;
        logic [63:0]        a0_v;
        logic [63:0]        b0_v;
        logic [63:0]        bitv;
        logic [63:0]        tr_v;
        logic [63:0]        q_v;
        logic [63:0]        oq_v;
        logic [127:0]       prod_v;
        logic [6:0]         len_v;
        logic [7:0]         jl_v;
        logic [32:0]        rem2_v;
        logic [32:0]        pabs_v;
        logic [31:0]        omlm_v;
        logic signed [18:0] da_v;
        logic [18:0]        dam_v;
        logic signed [31:0] p_v;

        lam_v  = $signed({47'd0, blend_weight_reg});
        eps_v  = $signed({47'd0, tolerance_reg});
        oml_v  = $signed(ONE) - lam_v;
        mag_v  = mag64(oml_v);
        omlm_v = mag_v[31:0];

        // Unpack the transfer, form the cross products and the friction bound
        n          = '0;
        n.contact  = s_tuser[0];
        n.nx       = $signed(s_tdata[17:0]);
        n.ny       = $signed(s_tdata[35:18]);
        n.u        = $signed(s_tdata[195:164]);
        p_v        = $signed(s_tdata[163:132]);
        n.px       = $signed(s_tdata[67:36]) * $signed(s_tdata[35:18]);
        n.py       = $signed(s_tdata[99:68]) * $signed(s_tdata[17:0]);
        pabs_v     = p_v[31] ? 33'(-$signed({p_v[31], p_v})) : {1'b0, p_v};
        n.mup      = {33'd0, friction_coeff_reg} * {31'd0, pabs_v};
        n.p_neg    = p_v[31];
        n.umag     = n.u[31] ? 33'(-$signed({n.u[31], n.u})) : {1'b0, n.u};
        n.lowp     = p_v < $signed({15'd0, tolerance_reg});
        n.u_nonneg = ~n.u[31];
        if (n.umag < {16'd0, tolerance_reg}) begin
            n.s_pos = 1'b1;
            n.s_neg = 1'b0;
        end else begin
            n.s_pos = ~n.u[31] && (n.u != 32'sd0);
            n.s_neg = n.u[31];
        end
        d_next[S_IN] = n;

        // Slip term and slack
        c      = d_reg[S_AB-1];
        n      = c;
        diff_v = c.px - c.py;
        mag_v  = mag64(diff_v) >> FRAC_BITS;
        vdt_v  = diff_v[63] ? -$signed(mag_v) : $signed(mag_v);
        n.a    = c.s_pos ? -vdt_v : (c.s_neg ? vdt_v : 64'sd0);
        mag_v  = c.mup >> FRAC_BITS;
        bm_v   = c.p_neg ? -$signed(mag_v) : $signed(mag_v);
        n.b    = bm_v - $signed({31'd0, c.umag});
        d_next[S_AB] = n;

        // Magnitudes, zero tests, shift count and the first product partials
        c         = d_reg[S_NRM-1];
        n         = c;
        n.amag    = mag64(c.a);
        n.bmag    = mag64(c.b);
        n.a_small = $signed(n.amag) < eps_v;
        n.b_small = $signed(n.bmag) < eps_v;
        len_v     = bit_len(n.amag | n.bmag);
        n.k       = (len_v > 7'd31) ? 7'(len_v - 7'd31) : 7'd0;
        a0_v      = (c.a > 64'sd0) ? 64'(c.a) : 64'd0;
        b0_v      = (c.b > 64'sd0) ? 64'(c.b) : 64'd0;
        n.t1_lo   = {32'd0, omlm_v} * {32'd0, a0_v[31:0]};
        n.t1_hi   = {32'd0, omlm_v} * {32'd0, a0_v[63:32]};
        n.t2_lo   = {32'd0, omlm_v} * {32'd0, b0_v[31:0]};
        n.t2_hi   = {32'd0, omlm_v} * {32'd0, b0_v[63:32]};
        d_next[S_NRM] = n;

        // Normalize for the root, finish the weighted positive parts
        c      = d_reg[S_SHF-1];
        n      = c;
        tr_v   = c.amag >> c.k;
        n.sa   = tr_v[30:0];
        tr_v   = c.bmag >> c.k;
        n.sb   = tr_v[30:0];
        prod_v = ({64'd0, c.t1_hi} << 32) + {64'd0, c.t1_lo};
        n.t1   = fin(prod_v, oml_v[63], FRAC_BITS);
        prod_v = ({64'd0, c.t2_hi} << 32) + {64'd0, c.t2_lo};
        n.t2   = fin(prod_v, oml_v[63], FRAC_BITS);
        d_next[S_SHF] = n;

        // Squares and partials of the product term
        c      = d_reg[S_SQ-1];
        n      = c;
        n.sq_a = {33'd0, c.sa} * {33'd0, c.sa};
        n.sq_b = {33'd0, c.sb} * {33'd0, c.sb};
        mag_v  = mag64(c.t1);
        b0_v   = (c.b > 64'sd0) ? 64'(c.b) : 64'd0;
        n.y00  = {32'd0, mag_v[31:0]} * {32'd0, b0_v[31:0]};
        n.y01  = {32'd0, mag_v[31:0]} * {32'd0, b0_v[63:32]};
        n.y10  = {32'd0, mag_v[63:32]} * {32'd0, b0_v[31:0]};
        n.y11  = {32'd0, mag_v[63:32]} * {32'd0, b0_v[63:32]};
        d_next[S_SQ] = n;

        // Radicand, product term
        c      = d_reg[S_RAD-1];
        n      = c;
        n.rem  = c.sq_a + c.sq_b;
        n.res  = 64'd0;
        prod_v = {64'd0, c.y00} + ({64'd0, c.y01} << 32) + ({64'd0, c.y10} << 32)
                 + ({64'd0, c.y11} << 64);
        n.y    = fin(prod_v, c.t1[63], FRAC_BITS);
        d_next[S_RAD] = n;

        // Square root, one result bit per stage
        for (int i = 0; i < NSQ; i++) begin
            c    = d_reg[SQ0+i-1];
            n    = c;
            bitv = 64'd1 << (62 - 2 * i);
            if (c.rem >= c.res + bitv) begin
                n.rem = c.rem - (c.res + bitv);
                n.res = (c.res >> 1) + bitv;
            end else begin
                n.res = c.res >> 1;
            end
            d_next[SQ0+i] = n;
        end

        // Radius, smooth term, divider shift
        c       = d_reg[S_R-1];
        n       = c;
        n.r     = c.res << c.k;
        n.dif   = c.a + c.b - $signed(n.r);
        n.rzero = (n.r == 64'd0);
        jl_v    = {1'b0, bit_len(c.res)} + {1'b0, c.k};
        n.j     = (jl_v > 8'd32) ? 7'(jl_v - 8'd32) : 7'd0;
        mag_v   = mag64(n.dif);
        n.x_lo  = {47'd0, blend_weight_reg} * {32'd0, mag_v[31:0]};
        n.x_hi  = {47'd0, blend_weight_reg} * {32'd0, mag_v[63:32]};
        d_next[S_R] = n;

        // Divider setup; a shifted numerator that reaches the shifted radius is a full ratio
        c        = d_reg[S_DP-1];
        n        = c;
        tr_v     = c.r >> c.j;
        n.rd     = tr_v[31:0];
        n.full_a = (c.amag >> c.j) >= (c.r >> c.j);
        n.full_b = (c.bmag >> c.j) >= (c.r >> c.j);
        tr_v     = c.amag >> c.j;
        n.rem_a  = tr_v[32:0];
        tr_v     = c.bmag >> c.j;
        n.rem_b  = tr_v[32:0];
        n.qa     = 32'd0;
        n.qb     = 32'd0;
        prod_v   = {64'd0, c.x_lo} + ({64'd0, c.x_hi} << 32);
        n.x      = fin(prod_v, c.dif[63], FRAC_BITS);
        d_next[S_DP] = n;

        // Restoring division, one quotient bit per stage
        for (int i = 0; i < FRAC_BITS; i++) begin
            c      = d_reg[DV0+i-1];
            n      = c;
            rem2_v = {c.rem_a[31:0], 1'b0};
            if (rem2_v >= {1'b0, c.rd}) begin
                n.rem_a = rem2_v - {1'b0, c.rd};
                n.qa    = {c.qa[30:0], 1'b1};
            end else begin
                n.rem_a = rem2_v;
                n.qa    = {c.qa[30:0], 1'b0};
            end
            rem2_v = {c.rem_b[31:0], 1'b0};
            if (rem2_v >= {1'b0, c.rd}) begin
                n.rem_b = rem2_v - {1'b0, c.rd};
                n.qb    = {c.qb[30:0], 1'b1};
            end else begin
                n.rem_b = rem2_v;
                n.qb    = {c.qb[30:0], 1'b0};
            end
            d_next[DV0+i] = n;
        end

        // Weighted smooth slopes
        c      = d_reg[S_G1-1];
        n      = c;
        q_v    = c.rzero ? 64'd0 : (c.full_a ? ONE : {32'd0, c.qa});
        oq_v   = c.a[63] ? ONE + q_v : ONE - q_v;
        mag_v  = ({47'd0, blend_weight_reg} * oq_v) >> FRAC_BITS;
        n.ml_a = $signed(mag_v);
        q_v    = c.rzero ? 64'd0 : (c.full_b ? ONE : {32'd0, c.qb});
        oq_v   = c.b[63] ? ONE + q_v : ONE - q_v;
        mag_v  = ({47'd0, blend_weight_reg} * oq_v) >> FRAC_BITS;
        n.ml_b = $signed(mag_v);
        d_next[S_G1] = n;

        // Pick each slope for its zero-test case, finish residual and self term
        c = d_reg[S_G2-1];
        n = c;
        if (c.a_small) begin
            bm_v = (c.b > 64'sd0) ? 64'sd0 : (lam_v <<< 1);
            n.g2 = (c.b >= 64'sd0) ? 64'sd0 : (lam_v <<< 1);
        end else begin
            bm_v = c.ml_b + ((c.b > 64'sd0) ? c.t1 : 64'sd0);
            n.g2 = c.ml_b + ((c.b >= 64'sd0) ? c.t1 : 64'sd0);
        end
        if (c.b_small) begin
            n.gv = (c.a > 64'sd0) ? 64'sd0 : (c.a[63] ? (lam_v <<< 1) : lam_v);
        end else begin
            n.gv = c.ml_a + ((c.a > 64'sd0) ? c.t2 : 64'sd0);
        end
        mag_v      = mag64(bm_v);
        n.jac_self = sat32(fin({64'd0, mag_v}, bm_v[63] ^ c.u_nonneg, 0));
        n.residual = sat32(c.x + c.y);
        d_next[S_G2] = n;

        // Partials of the pressure and velocity products
        c       = d_reg[S_J1-1];
        n       = c;
        mag_v   = mag64(c.g2);
        n.jp_lo = {33'd0, friction_coeff_reg} * {32'd0, mag_v[31:0]};
        n.jp_hi = {33'd0, friction_coeff_reg} * {32'd0, mag_v[63:32]};
        mag_v   = mag64(c.gv);
        da_v    = c.s_pos ? -19'(c.ny) : (c.s_neg ? 19'(c.ny) : 19'sd0);
        dam_v   = da_v[18] ? 19'(-da_v) : 19'(da_v);
        n.dax_neg = da_v[18];
        n.vx_lo = {45'd0, dam_v} * {32'd0, mag_v[31:0]};
        n.vx_hi = {45'd0, dam_v} * {32'd0, mag_v[63:32]};
        da_v    = c.s_pos ? 19'(c.nx) : (c.s_neg ? -19'(c.nx) : 19'sd0);
        dam_v   = da_v[18] ? 19'(-da_v) : 19'(da_v);
        n.day_neg = da_v[18];
        n.vy_lo = {45'd0, dam_v} * {32'd0, mag_v[31:0]};
        n.vy_hi = {45'd0, dam_v} * {32'd0, mag_v[63:32]};
        d_next[S_J1] = n;

        // Finish the products, apply no-contact and low-pressure cases
        c      = d_reg[S_J2-1];
        n      = c;
        prod_v = {64'd0, c.jp_lo} + ({64'd0, c.jp_hi} << 32);
        n.jac_pressure = sat32(fin(prod_v, c.g2[63], FRAC_BITS));
        prod_v = {64'd0, c.vx_lo} + ({64'd0, c.vx_hi} << 32);
        n.jac_vel_x = sat32(fin(prod_v, c.gv[63] ^ c.dax_neg, FRAC_BITS));
        prod_v = {64'd0, c.vy_lo} + ({64'd0, c.vy_hi} << 32);
        n.jac_vel_y = sat32(fin(prod_v, c.gv[63] ^ c.day_neg, FRAC_BITS));
        if (!c.contact) begin
            n.residual     = 32'd0;
            n.jac_self     = 32'd0;
            n.jac_pressure = 32'd0;
            n.jac_vel_x    = 32'd0;
            n.jac_vel_y    = 32'd0;
        end else if (c.lowp) begin
            n.residual     = c.u;
            n.jac_self     = sat32($signed(ONE));
            n.jac_pressure = 32'd0;
            n.jac_vel_x    = 32'd0;
            n.jac_vel_y    = 32'd0;
        end
        d_next[S_J2] = n;
    end

endmodule

FILE: verif/friction_ncp_residual_jacobian_chk.sv
// Checker: watches the configuration port and both streams, predicts each result and compares.
`timescale 1ns / 100ps

module friction_ncp_residual_jacobian_chk (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    output int           errors,
    output int           pending,
    output int           results_seen
);
    import fncp_pkg::*;

    localparam longint ONE = 64'sd65536;
    localparam logic [63:0] MAG_CAP = 64'h2000_0000_0000_0000;

    typedef struct {
        logic [31:0] f[5];
    } jac_row_t;

    string field_name[5] = '{"residual", "jac_self", "jac_pressure", "jac_vel_x", "jac_vel_y"};

    // live copy of the coefficient registers
    logic [30:0] mu_q;
    logic [16:0] lam_q;
    logic [16:0] eps_q;

    jac_row_t expected_rows[$];

    function automatic logic [63:0] absval(input longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint capped(input logic [63:0] m, input bit neg);
        if (m > MAG_CAP) m = MAG_CAP;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint trunc_shift(input longint x);
        return capped(absval(x) >> 16, x < 0);
    endfunction

    function automatic longint qmul(input longint x, input longint y);
        logic [127:0] ux, uy, p;
        logic [63:0]  m;
        ux = absval(x);
        uy = absval(y);
        p = ux * uy;
        if (p[127:64] != 0) m = MAG_CAP;
        else m = p[63:0] >> 16;
        return capped(m, (x < 0) != (y < 0));
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] hypot_mag(input longint a, input longint b);
        logic [63:0] ma, mb;
        int k;
        ma = absval(a);
        mb = absval(b);
        k = 0;
        while ((ma >> k) >= 64'h8000_0000 || (mb >> k) >= 64'h8000_0000) k++;
        ma >>= k;
        mb >>= k;
        return int_sqrt(ma * ma + mb * mb) << k;
    endfunction

    function automatic longint unit_ratio(input longint x, input logic [63:0] r);
        logic [63:0] mx, q;
        mx = absval(x);
        if (r == 0) return 0;
        if (mx >= r) begin
            q = ONE;
        end else begin
            while (r >= 64'h1_0000_0000) begin
                r >>= 1;
                mx >>= 1;
            end
            q = (mx << 16) / r;
            if (q > ONE) q = ONE;
        end
        return capped(q, x < 0);
    endfunction

    function automatic logic [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // residual and Jacobian row of one contact node
    function automatic jac_row_t node_row(input logic [199:0] d, input logic contact);
        jac_row_t row;
        longint nx, ny, vx, vy, p, u, mu, lam, eps, oml;
        longint vdt, s, a, b, a0, b0, g, q, sa, dax, day;
        logic [63:0] r;
        nx = longint'($signed(d[17:0]));
        ny = longint'($signed(d[35:18]));
        vx = longint'($signed(d[67:36]));
        vy = longint'($signed(d[99:68]));
        p  = longint'($signed(d[163:132]));
        u  = longint'($signed(d[195:164]));
        mu = longint'(mu_q);
        lam = longint'(lam_q);
        eps = longint'(eps_q);
        oml = ONE - lam;
        foreach (row.f[i]) row.f[i] = 0;
        if (!contact) return row;
        if (p < eps) begin
            row.f[0] = clamp32(u);
            row.f[1] = clamp32(ONE);
            return row;
        end
        vdt = trunc_shift(vx * ny - vy * nx);
        s = (longint'(absval(u)) < eps) ? 1 : (u > 0 ? 1 : (u < 0 ? -1 : 0));
        a = s > 0 ? -vdt : (s < 0 ? vdt : 0);
        b = qmul(mu, p) - longint'(absval(u));
        a0 = a > 0 ? a : 0;
        b0 = b > 0 ? b : 0;
        r = hypot_mag(a, b);
        row.f[0] = clamp32(qmul(lam, a + b - longint'(r)) + qmul(qmul(oml, a0), b0));

        // multiplier slope, then pressure slope; near-zero slip takes the kink form
        if (longint'(absval(a)) < eps) begin
            g = qmul(lam, b > 0 ? 0 : 2 * ONE);
        end else begin
            q = unit_ratio(b, r);
            g = qmul(lam, ONE - q) + (b > 0 ? qmul(oml, a0) : 0);
        end
        row.f[1] = clamp32(qmul(g, u >= 0 ? -ONE : ONE));
        if (longint'(absval(a)) < eps) begin
            g = qmul(lam, b >= 0 ? 0 : 2 * ONE);
        end else begin
            q = unit_ratio(b, r);
            g = qmul(lam, ONE - q) + (b >= 0 ? qmul(oml, a0) : 0);
        end
        row.f[2] = clamp32(qmul(g, mu));

        // shared velocity factor
        if (longint'(absval(b)) < eps) begin
            sa = a > 0 ? 1 : (a < 0 ? -1 : 0);
            g = qmul(lam, ONE - sa * ONE);
        end else begin
            q = unit_ratio(a, r);
            g = qmul(lam, ONE - q) + (a > 0 ? qmul(oml, b0) : 0);
        end
        dax = s > 0 ? -ny : (s < 0 ? ny : 0);
        day = s > 0 ? nx : (s < 0 ? -nx : 0);
        row.f[3] = clamp32(qmul(g, dax));
        row.f[4] = clamp32(qmul(g, day));
        return row;
    endfunction

    assign pending = expected_rows.size();

    always @(posedge aclk) begin
        jac_row_t want;
        int       miss;
        miss = 0;
        if (!aresetn) begin
            mu_q <= FRICTION_RST;
            lam_q <= BLEND_RST;
            eps_q <= TOL_RST;
            expected_rows.delete();
            errors <= 0;
            results_seen <= 0;
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FRICTION: mu_q <= cfg_data;
                    REG_BLEND:    lam_q <= cfg_data[16:0];
                    REG_TOL:      eps_q <= cfg_data[16:0];
                    default: ;
                endcase
            end
            // predict on each input transfer
            if (s_tvalid && s_tready)
                expected_rows.insert(expected_rows.size(), node_row(s_tdata, s_tuser[0]));
            // compare each output transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (expected_rows.size() == 0) begin
                    $error("result transfer with nothing expected");
                    miss = 1;
                end else begin
                    want = expected_rows.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (m_tdata[32*i +: 32] !== want.f[i]) begin
                            $error("%s: expected %h, got %h", field_name[i], want.f[i],
                                   m_tdata[32*i +: 32]);
                            miss = miss + 1;
                        end
                    end
                end
                if (miss != 0) errors <= errors + miss;
            end
        end
    end

endmodule

FILE: verif/friction_ncp_residual_jacobian_tb.sv
// Testbench top: clock, reset, configuration phases, node stimulus and the verdict.
`timescale 1ns / 100ps

module friction_ncp_residual_jacobian_tb;
    import fncp_pkg::*;

    localparam int LATENCY = 60;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_NODES = 190;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [30:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;

    int errors, pending, results_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int nodes_sent = 0;
    int idle_run = 0;

    always #4 aclk = ~aclk;

    friction_ncp_residual_jacobian dut (.*);

    friction_ncp_residual_jacobian_chk chk (.*);

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("friction_ncp_residual_jacobian verification failed");
            $finish;
        end
    end

    // drive one node and hold it until transferred
    task automatic send_node(input logic contact, input logic [17:0] nx, input logic [17:0] ny,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz, input logic [31:0] p,
                             input logic [31:0] u);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= contact;
        s_tdata  <= {4'd0, u, p, vz, vy, vx, ny, nx};
        do @(posedge aclk); while (!s_tready);
        nodes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // signed value with a spread of magnitudes: full range, small, extreme, near zero
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
            4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 4)) - 2);
        endcase
    endfunction

    function automatic logic [17:0] pick_normal();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic random_node();
        logic [31:0] p;
        p = pick32();
        // keep most pressures past the low-pressure shortcut
        if ($urandom_range(0, 9) < 7 && $signed(p) < 2) p = $urandom_range(2, 1 << 22);
        send_node($urandom_range(0, 19) != 0, pick_normal(), pick_normal(), pick32(), pick32(),
                  $urandom, p, pick32());
    endtask

    initial begin
        int mu_set[6]  = '{0, 32768, 2147483647, 65536, 196608, 13107};
        int lam_set[6] = '{65536, 0, 62259, 32768, 65536, 62259};
        int eps_set[6] = '{1, 0, 65536, 655, 0, 1};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(REG_FRICTION, 31'd65536);
        // directed nodes: no contact, low pressure, small slip, small slack, extremes
        send_node(1'b0, 18'sd65536, 18'sd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 32'd1);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd65536, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd65536, 32'd0, 32'd0, 32'd65536, 32'd65536);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'hFFFF_0000, 32'd0, 32'd0, 32'd65536, 32'hFFFF_0000);
        send_node(1'b1, -18'sd65536, 18'sd0, 32'd0, 32'd65536, 32'hFFFF_FFFF, 32'd131072, 32'd0);
        send_node(1'b1, 18'sd46341, 18'sd46341, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h8000_0000);
        send_node(1'b1, -18'sd65536, -18'sd65536, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_node(1'b1, 18'sd1, -18'sd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0);
        send_node(1'b1, 18'sd65536, 18'sd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd3000, 32'd0, 32'd0, 32'd70000, 32'd65536);
        drain();
        // zero tolerance with zero multiplier makes the slip vanish
        write_reg(REG_TOL, 31'd0);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0);
        send_node(1'b1, 18'sd0, 18'sd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd5);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_FRICTION, 31'(mu_set[ph]));
            write_reg(REG_BLEND, 31'(lam_set[ph]));
            write_reg(REG_TOL, 31'(eps_set[ph]));
            send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 74 : 0;
            recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 15 : 0;
            if (ph == 4) hold_cycles = 400;
            for (int i = 0; i < PHASE_NODES; i++) begin
                random_node();
                // pause the sender mid-phase until everything is back
                if (i == PHASE_NODES / 2 && ph == 1) begin
                    s_tvalid <= 1'b0;
                    wait (pending == 0);
                    @(negedge aclk);
                end
            end
            drain();
        end

        $display("covered %0d nodes over six coefficient settings (%0d results checked),",
                 nodes_sent, results_seen);
        $display("with sender and receiver stalls, a long output hold-off and a full drain");
        if (errors == 0) begin
            $display("friction_ncp_residual_jacobian verification clean");
        end else begin
            $display("friction_ncp_residual_jacobian verification failed");
        end
        $finish;
    end

endmodule
